// ===== rtl/spt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the stepper position tracker: stream widths, field
// positions, item kinds and the reciprocal constants of the two divisions.
// No dependencies.
package spt_pkg;

	// item kind on s_tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	// input tdata field positions
	localparam int DT_LSB    = 0;
	localparam int DT_W      = 10;
	localparam int ANGLE_LSB = 10;
	localparam int ANGLE_W   = 16;
	localparam int SPEED_LSB = 26;
	localparam int SPEED_W   = 16;
	localparam int EN_BIT    = 42;

	// output tdata field positions
	localparam int STEP_LSB = 0;
	localparam int STEP_W   = 32;
	localparam int DIR_BIT  = 32;
	localparam int ENA_BIT  = 33;
	localparam int POSN_BIT = 34;
	localparam int RATE_LSB = 35;
	localparam int RATE_W   = 16;

	localparam logic [15:0] SPR_RESET = 16'd200;

	// angle product / 3600: floor(2^43 / 3600), estimate is low by at most one
	localparam logic [31:0] DIV_A      = 32'd3600;
	localparam logic [31:0] RECIP_A    = 32'd2443359172;
	localparam int          RECIP_A_SH = 43;
	localparam int          QA_W       = 20;

	// step delta / 1000: floor(2^30 / 1000), estimate is low by at most one
	localparam logic [25:0] DIV_D      = 26'd1000;
	localparam logic [20:0] RECIP_D    = 21'd1073741;
	localparam int          RECIP_D_SH = 30;
	localparam int          DELTA_W    = 26;
	localparam int          QD_W       = 17;

endpackage

// ===== rtl/stepper_position_tracker.sv =====
`timescale 1ns / 1ps
// Stepper position tracker: open-loop step count, direction and enable control.
// Depends on spt_pkg.
//
// Pipeline: one item per cycle while m_tready does not hold the output; four stages
// (multiply, reciprocal multiply, quotient correction, state update) feed an
// output register, which drives m_tvalid and m_tdata.
// Reset: arst_n clears the tracking state and stage valids, not the stage or output
// data; the revolution step count returns to 200.
module stepper_position_tracker import spt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// dt_ms[9:0], target_angle[25:10], speed[41:26], enable_request[42], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// step_count[31:0], dir_out[32], enabled_out[33], positioning[34],
	// rate_out[50:35], zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata
);

	// stage valids and handshake chain
	logic v1_s1, v2_s2, v3_s3, v4_s4, out_v_q;
	logic out_free, rdy4, rdy3, rdy2, in_acc;

	assign out_free = !out_v_q || m_tready;
	assign rdy4     = !v4_s4 || out_free;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign s_tready = !v1_s1 || rdy2;
	assign in_acc   = s_tvalid && s_tready;

	logic [15:0] spr_q;
	logic [15:0] rate_ahead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q        <= SPR_RESET;
			rate_ahead_q <= '0;
		end else begin
			if (cfg_we)
				spr_q <= cfg_wdata;
			if (in_acc && s_tuser == OP_CMD)
				rate_ahead_q <= s_tdata[SPEED_LSB +: SPEED_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready)
				v1_s1 <= s_tvalid;
			if (rdy2)
				v2_s2 <= v1_s1;
			if (rdy3)
				v3_s3 <= v2_s2;
			if (rdy4)
				v4_s4 <= v3_s3;
			if (out_free)
				out_v_q <= v4_s4;
		end
	end

	// ---------------- stage 1: products
	logic              op_s1, en_s1;
	logic [DT_W-1:0]   dt_s1;
	logic [15:0]       angle_s1, speed_s1, rate_s1;
	logic [15:0]       amag;
	logic [31:0]       prod_a;
	logic [DELTA_W-1:0] delta;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= s_tuser;
			dt_s1    <= s_tdata[DT_LSB +: DT_W];
			angle_s1 <= s_tdata[ANGLE_LSB +: ANGLE_W];
			speed_s1 <= s_tdata[SPEED_LSB +: SPEED_W];
			en_s1    <= s_tdata[EN_BIT];
			rate_s1  <= rate_ahead_q; // rate left by all earlier items
		end
	end

	// magnitude of the angle; -32768 maps to 0x8000
	assign amag   = angle_s1[15] ? (~angle_s1 + 16'd1) : angle_s1;
	assign prod_a = {16'd0, amag} * {16'd0, spr_q};
	assign delta  = {16'd0, dt_s1} * {10'd0, rate_s1};

	// ---------------- stage 2: reciprocal multiplies
	logic               op_s2, en_s2, neg_s2;
	logic [15:0]        speed_s2;
	logic [31:0]        prod_a_s2;
	logic [DELTA_W-1:0] delta_s2;
	logic [62:0]        pa_full;
	logic [46:0]        pd_full;

	always_ff @(posedge clk) begin
		if (v1_s1 && rdy2) begin
			op_s2     <= op_s1;
			en_s2     <= en_s1;
			neg_s2    <= angle_s1[15];
			speed_s2  <= speed_s1;
			prod_a_s2 <= prod_a;
			delta_s2  <= delta;
		end
	end

	assign pa_full = {31'd0, prod_a_s2} * {31'd0, RECIP_A};
	assign pd_full = {21'd0, delta_s2} * {26'd0, RECIP_D};

	// ---------------- stage 3: quotient correction
	logic               op_s3, en_s3, neg_s3;
	logic [15:0]        speed_s3;
	logic [31:0]        prod_a_s3;
	logic [DELTA_W-1:0] delta_s3;
	logic [QA_W-1:0]    qa0_s3, qa;
	logic [QD_W-1:0]    qd0_s3, qd;
	logic [31:0]        ra;
	logic [DELTA_W-1:0] rd, rd_fix;
	logic [31:0]        tgt;

	always_ff @(posedge clk) begin
		if (v2_s2 && rdy3) begin
			op_s3     <= op_s2;
			en_s3     <= en_s2;
			neg_s3    <= neg_s2;
			speed_s3  <= speed_s2;
			prod_a_s3 <= prod_a_s2;
			delta_s3  <= delta_s2;
			qa0_s3    <= pa_full[RECIP_A_SH +: QA_W];
			qd0_s3    <= pd_full[RECIP_D_SH +: QD_W];
		end
	end

	assign ra     = prod_a_s3 - {12'd0, qa0_s3} * DIV_A;
	assign qa     = (ra >= DIV_A) ? qa0_s3 + QA_W'(1) : qa0_s3;
	assign tgt    = neg_s3 ? (32'd0 - {12'd0, qa}) : {12'd0, qa};
	assign rd     = delta_s3 - {9'd0, qd0_s3} * DIV_D;
	assign qd     = (rd >= DIV_D) ? qd0_s3 + QD_W'(1) : qd0_s3;
	assign rd_fix = (rd >= DIV_D) ? rd - DIV_D : rd;

	// ---------------- stage 4: state update
	logic            op_s4, en_s4;
	logic [15:0]     speed_s4;
	logic [31:0]     tgt_s4;
	logic [QD_W-1:0] qd_s4;
	logic [9:0]      rd_s4;

	always_ff @(posedge clk) begin
		if (v3_s3 && rdy4) begin
			op_s4    <= op_s3;
			en_s4    <= en_s3;
			speed_s4 <= speed_s3;
			tgt_s4   <= tgt;
			qd_s4    <= qd;
			rd_s4    <= rd_fix[9:0];
		end
	end

	// err_q tracks target - position, so a tick needs no separate subtract
	logic signed [10:0] frac_q;
	logic [31:0]        pos_q, err_q;
	logic               dir_q, en_q, pm_q;
	logic [15:0]        rate_q;

	logic [QD_W-1:0]    q_g;
	logic [9:0]         r_g, b;
	logic signed [11:0] m;
	logic signed [2:0]  a;
	logic signed [18:0] qs, qf, whole;
	logic signed [10:0] frac_t;
	logic [31:0]        whole32, pos_t, err_t, err_c;

	logic signed [10:0] frac_n;
	logic [31:0]        pos_n, err_n;
	logic               dir_n, en_n, pm_n;
	logic [15:0]        rate_n;

	always_comb begin
		q_g = en_q ? qd_s4 : '0;
		r_g = en_q ? rd_s4 : '0;
		m   = {frac_q[10], frac_q} + (dir_q ? $signed({2'b00, r_g}) : -$signed({2'b00, r_g}));

		// floor split of m into a*1000 + b, b in 0..999
		if (m >= 12'sd1000) begin
			a = 3'sd1;
			b = 10'(m - 12'sd1000);
		end else if (m >= 12'sd0) begin
			a = 3'sd0;
			b = 10'(m);
		end else if (m >= -12'sd1000) begin
			a = -3'sd1;
			b = 10'(m + 12'sd1000);
		end else begin
			a = -3'sd2;
			b = 10'(m + 12'sd2000);
		end

		qs = dir_q ? $signed({2'b00, q_g}) : -$signed({2'b00, q_g});
		qf = qs + {{16{a[2]}}, a};

		// floor to truncation: remainder takes the sign of the sum
		if (qf < 19'sd0 && b != 10'd0) begin
			whole  = qf + 19'sd1;
			frac_t = $signed({1'b0, b}) - 11'sd1000;
		end else begin
			whole  = qf;
			frac_t = $signed({1'b0, b});
		end

		whole32 = {{13{whole[18]}}, whole};
		pos_t   = pos_q + whole32;
		err_t   = err_q - whole32;
		err_c   = tgt_s4 - pos_q;

		frac_n = frac_q;
		pos_n  = pos_q;
		err_n  = err_q;
		dir_n  = dir_q;
		en_n   = en_q;
		pm_n   = pm_q;
		rate_n = rate_q;

		if (op_s4 == OP_CMD) begin
			err_n  = err_c;
			dir_n  = !err_c[31] && (err_c != 32'd0);
			pm_n   = 1'b1;
			rate_n = speed_s4;
			en_n   = en_s4;
		end else begin
			frac_n = frac_t;
			pos_n  = pos_t;
			err_n  = err_t;
			if (pm_q) begin
				if (err_t == 32'd0 || err_t == 32'd1 || err_t == 32'hFFFF_FFFF) begin
					en_n = 1'b0;
					pm_n = 1'b0;
				end else begin
					dir_n = !err_t[31];
				end
			end
		end
	end

	wire upd = v4_s4 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= '0;
			pos_q  <= '0;
			err_q  <= '0;
			dir_q  <= 1'b0;
			en_q   <= 1'b0;
			pm_q   <= 1'b0;
			rate_q <= '0;
		end else if (upd) begin
			frac_q <= frac_n;
			pos_q  <= pos_n;
			err_q  <= err_n;
			dir_q  <= dir_n;
			en_q   <= en_n;
			pm_q   <= pm_n;
			rate_q <= rate_n;
		end
	end

	// ---------------- output register
	logic [OUT_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk) begin
		if (upd) begin
			out_data_q <= {5'd0, rate_n, pm_n, en_n, dir_n, pos_n};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/spt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stepper position tracker, bound to the top level.
// Depends on spt_pkg and stepper_position_tracker.
module spt_checker import spt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// items in flight: four stages plus the output register
	logic [3:0] occ_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else
			occ_q <= occ_q + {3'd0, in_acc} - {3'd0, out_acc};
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ_q != 4'd0)
		else $error("result with no item in flight");

	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 4'd5)
		else $error("more items in flight than stages");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output register empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind stepper_position_tracker spt_checker u_spt_checker (.*);
